@@ sv/psio_pkg.sv @@
// psio_pkg: shared widths, register codes, pipeline stage map and helper
// functions for the pixel stretch/invert/overlay block.
// No dependencies; imported by psio_div and pixel_stretch_invert_overlay.
package psio_pkg;

  // Sample and datapath widths
  localparam int SAMPLE_W   = 10;
  localparam int FULL_W     = 16;
  localparam int QUO_W      = FULL_W;
  localparam int PROD_W     = FULL_W + SAMPLE_W;
  localparam int LEVEL_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [FULL_W-1:0] FULL_SCALE = FULL_W'((1 << SAMPLE_W) - 1);
  localparam logic [FULL_W-1:0] BYTE_SCALE = FULL_W'(8'hff);
  localparam logic [FULL_W-1:0] WORD_CLIP  = FULL_W'(16'h3ff);
  localparam logic [3:0]        SHIFT_MAX  = 4'd8;
  localparam logic [3:0]        SHIFT_RESET = 4'd2;
  localparam logic [3:0]        ADAPT_SHIFT = 4'd2;
  // (x + 1) * 0x1111 >> 16 equals x / 15 for x below 3840
  localparam logic [24:0]       NIB_RECIP  = 25'h1111;

  // Divider: quotient bits retired per stage
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS   = QUO_W / DIV_STAGES;

  // Pipeline stage map
  localparam int ST_SUB      = 0;
  localparam int ST_MUL      = 1;
  localparam int ST_DIV0     = 2;
  localparam int ST_RED      = ST_DIV0 + DIV_STAGES;
  localparam int ST_OUT      = ST_RED + 1;
  localparam int PIPE_STAGES = ST_OUT + 1;

  // control_flags bit positions
  localparam int FLAG_ADAPT = 0;
  localparam int FLAG_INV   = 1;
  localparam int FLAG_DEEP  = 2;
  localparam int FLAG_3D    = 3;
  localparam int FLAG_OVL   = 4;
  localparam int FLAG_GRID  = 5;
  localparam int FLAG_FIRE  = 6;
  localparam int FLAG_MARK  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUM_MIN     = 3'd0,
    REG_LUM_MAX     = 3'd1,
    REG_OUT_MODE    = 3'd2,
    REG_CTRL_FLAGS  = 3'd3,
    REG_BIT_SHIFT   = 3'd4,
    REG_OVL_LEVEL   = 3'd5,
    REG_OVL_COLOURS = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_COLOUR    = 2'd0,
    MODE_BYTE      = 2'd1,
    MODE_BYTE_WORD = 2'd2,
    MODE_WORD      = 2'd3
  } out_mode_e;

  // Per-pixel overlay bits as they travel down the pipe
  typedef struct packed {
    logic coast;
    logic coast_l;
    logic grid;
    logic fire;
    logic mark;
  } marks_t;

  typedef struct packed {
    logic [2:0][SAMPLE_W-1:0] pix;
    logic                     space;
    marks_t                   marks;
  } side_t;

  // Values that follow from the registers alone
  typedef struct packed {
    logic [FULL_W-1:0]            full;
    logic [SAMPLE_W-1:0]          den;
    logic                         stretch;
    logic [3:0]                   sh;
    logic [2:0][LEVEL_W-1:0]      tint_ovl;
    logic [2:0][LEVEL_W-1:0]      tint_grid;
    logic [SAMPLE_W-1:0]          word_add;
  } dcfg_t;

  function automatic logic [BYTE_W-1:0] sat8(input logic [FULL_W-1:0] v);
    return (v > BYTE_SCALE) ? 8'hff : v[BYTE_W-1:0];
  endfunction

  // nibble * level / 15
  function automatic logic [LEVEL_W-1:0] nib_tint(input logic [3:0] nib,
                                                   input logic [LEVEL_W-1:0] lvl);
    logic [11:0] x;
    logic [24:0] m;
    x = 12'(nib) * 12'(lvl);
    m = (25'(x) + 25'd1) * NIB_RECIP;
    return m[23:16];
  endfunction

  // n * x for n in 0..4
  function automatic logic [11:0] mul_n(input logic [2:0] n, input logic [9:0] x);
    logic [11:0] xw;
    xw = 12'(x);
    case (n)
      3'd0:    return 12'd0;
      3'd1:    return xw;
      3'd2:    return xw << 1;
      3'd3:    return xw + (xw << 1);
      3'd4:    return xw << 2;
      default: return 12'd0;
    endcase
  endfunction

endpackage

@@ sv/psio_div.sv @@
// psio_div: pipelined restoring divider, PROD_W / SAMPLE_W bits, quotient
// saturated to QUO_W bits; DIV_BITS quotient bits per stage.
// Depends on psio_pkg.
module psio_div (
  input  logic                                clk_i,
  input  logic [psio_pkg::DIV_STAGES-1:0]     en_i,
  input  logic [psio_pkg::PROD_W-1:0]         num_i,
  input  logic [psio_pkg::SAMPLE_W-1:0]       den_i,
  output logic [psio_pkg::QUO_W-1:0]          quo_o
);
  import psio_pkg::*;

  logic [DIV_STAGES-1:0][SAMPLE_W-1:0] src_rem, rem_d, rem_q;
  logic [DIV_STAGES-1:0][QUO_W-1:0]    src_low, low_d, low_q;
  logic [DIV_STAGES-1:0][QUO_W-1:0]    src_quo, quo_d, quo_q;
  logic [DIV_STAGES-1:0]               src_sat, sat_d, sat_q;

  // stage inputs; overflow when the top part already reaches the divisor
  always_comb begin
    src_rem[0] = num_i[PROD_W-1:QUO_W];
    src_low[0] = num_i[QUO_W-1:0];
    src_quo[0] = '0;
    src_sat[0] = (num_i[PROD_W-1:QUO_W] >= den_i);
    for (int j = 1; j < DIV_STAGES; j++) begin
      src_rem[j] = rem_q[j-1];
      src_low[j] = low_q[j-1];
      src_quo[j] = quo_q[j-1];
      src_sat[j] = sat_q[j-1];
    end
  end

  always_comb begin
    logic [SAMPLE_W:0]   t;
    logic [SAMPLE_W-1:0] r;
    logic [QUO_W-1:0]    q;
    for (int j = 0; j < DIV_STAGES; j++) begin
      r = src_rem[j];
      q = src_quo[j];
      for (int k = 0; k < DIV_BITS; k++) begin
        t = {r, src_low[j][QUO_W-1-DIV_BITS*j-k]};
        if (t >= {1'b0, den_i}) begin
          r = SAMPLE_W'(t - {1'b0, den_i});
          q[QUO_W-1-DIV_BITS*j-k] = 1'b1;
        end else begin
          r = t[SAMPLE_W-1:0];
        end
      end
      rem_d[j] = r;
      quo_d[j] = q;
      low_d[j] = src_low[j];
      sat_d[j] = src_sat[j];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d[j];
        low_q[j] <= low_d[j];
        quo_q[j] <= quo_d[j];
        sat_q[j] <= sat_d[j];
      end
    end
  end

  assign quo_o = sat_q[DIV_STAGES-1] ? '1 : quo_q[DIV_STAGES-1];

endmodule

@@ sv/pixel_stretch_invert_overlay.sv @@
// pixel_stretch_invert_overlay: window stretch, invert, depth reduction and
// overlay tinting of one RGB pixel per clock while the output is not stalled.
// Depends on psio_pkg and psio_div.
//
// Channel | Dir | Handshake                | Payload
// --------+-----+--------------------------+--------------------------------------
// in      | in  | in_valid_i / in_ready_o  | red/green/blue_in_i, five mark bits
// out     | out | out_valid_o / out_ready_i| red/green/blue_out_o, mono_out_o
// cfg     | in  | cfg_we_i, no wait        | cfg_idx_i, cfg_wdata_i
//
// One item per clock sustained while out_ready_i stays high; PIPE_STAGES stages
// lie from accept to out_valid_o, and the stretch divide retires four quotient
// bits in each of its four stages.
// Reset clears the valid bits and loads the register reset values.
// A stage holds while the next one is full and stalled; empty stages fill, so
// bubbles close up and only a full pipe drops in_ready_o.
module pixel_stretch_invert_overlay (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [psio_pkg::SAMPLE_W-1:0]     red_in_i,
  input  logic [psio_pkg::SAMPLE_W-1:0]     green_in_i,
  input  logic [psio_pkg::SAMPLE_W-1:0]     blue_in_i,
  input  logic                              coast_bit_i,
  input  logic                              coast_left_bit_i,
  input  logic                              grid_bit_i,
  input  logic                              fire_bit_i,
  input  logic                              mark_bit_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [psio_pkg::BYTE_W-1:0]       red_out_o,
  output logic [psio_pkg::BYTE_W-1:0]       green_out_o,
  output logic [psio_pkg::BYTE_W-1:0]       blue_out_o,
  output logic [psio_pkg::FULL_W-1:0]       mono_out_o,
  input  logic                              cfg_we_i,
  input  logic [psio_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [psio_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import psio_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SAMPLE_W-1:0]   lum_min_q, lum_max_q;
  out_mode_e             mode_q;
  logic [7:0]            flags_q;
  logic [3:0]            bit_shift_q;
  logic [LEVEL_W-1:0]    level_q;
  logic [CFG_DATA_W-1:0] colours_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lum_min_q   <= '0;
      lum_max_q   <= '0;
      mode_q      <= MODE_COLOUR;
      flags_q     <= '0;
      bit_shift_q <= SHIFT_RESET;
      level_q     <= '0;
      colours_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LUM_MIN:     lum_min_q   <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_LUM_MAX:     lum_max_q   <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_OUT_MODE:    mode_q      <= out_mode_e'(cfg_wdata_i[1:0]);
        REG_CTRL_FLAGS:  flags_q     <= cfg_wdata_i[7:0];
        REG_BIT_SHIFT:   bit_shift_q <= cfg_wdata_i[3:0];
        REG_OVL_LEVEL:   level_q     <= cfg_wdata_i[LEVEL_W-1:0];
        REG_OVL_COLOURS: colours_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic adapt, inv, deep, d3, win_eq;
  assign adapt  = flags_q[FLAG_ADAPT];
  assign inv    = flags_q[FLAG_INV];
  assign deep   = flags_q[FLAG_DEEP];
  assign d3     = flags_q[FLAG_3D];
  assign win_eq = (lum_min_q == lum_max_q);

  // Values derived from the registers. Registered once: they are first used
  // in the multiply stage, behind the SUB stage register.
  dcfg_t dcfg_d, dcfg_q;
  logic [1:0] lvl_div85;

  always_comb begin
    dcfg_d.sh = (bit_shift_q > SHIFT_MAX) ? SHIFT_MAX : bit_shift_q;
    if (!deep) begin
      dcfg_d.full = BYTE_SCALE;
    end else if (adapt) begin
      dcfg_d.full = FULL_SCALE;
    end else if (mode_q == MODE_COLOUR || mode_q == MODE_BYTE_WORD) begin
      dcfg_d.full = BYTE_SCALE << dcfg_d.sh;
    end else begin
      dcfg_d.full = FULL_SCALE;
    end
    // equal bounds select the whole sample range
    dcfg_d.den     = win_eq ? FULL_SCALE[SAMPLE_W-1:0] : lum_max_q - lum_min_q;
    dcfg_d.stretch = adapt && (win_eq || (lum_max_q > lum_min_q));
    for (int i = 0; i < 3; i++) begin
      dcfg_d.tint_ovl[i]  = nib_tint(colours_q[20-4*i +: 4], level_q);
      dcfg_d.tint_grid[i] = nib_tint(colours_q[8-4*i +: 4], level_q);
    end
    // 0x3ff * level / 0xff = 4 * level + level / 85
    if (level_q >= 8'd255) begin
      lvl_div85 = 2'd3;
    end else if (level_q >= 8'd170) begin
      lvl_div85 = 2'd2;
    end else if (level_q >= 8'd85) begin
      lvl_div85 = 2'd1;
    end else begin
      lvl_div85 = 2'd0;
    end
    dcfg_d.word_add = {level_q, 2'b00} + SAMPLE_W'(lvl_div85);
  end

  always_ff @(posedge clk_i) begin
    dcfg_q <= dcfg_d;
  end

  // ---------------------------------------------------------------------
  // Pipeline control: valid bit per stage, ready ripples back from output
  // ---------------------------------------------------------------------
  logic [PIPE_STAGES-1:0] v_q;
  logic [PIPE_STAGES:0]   rdy;

  always_comb begin
    rdy[PIPE_STAGES] = out_ready_i;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[PIPE_STAGES-1];

  // ---------------------------------------------------------------------
  // Stage SUB: distance above the window floor
  // ---------------------------------------------------------------------
  side_t                       side_q [ST_RED];
  side_t                       side_in;
  logic [2:0][SAMPLE_W-1:0]    dist_d, dist_q;
  logic [SAMPLE_W-1:0]         lmin_eff;

  assign lmin_eff = win_eq ? '0 : lum_min_q;

  always_comb begin
    side_in.pix[0]        = red_in_i;
    side_in.pix[1]        = green_in_i;
    side_in.pix[2]        = blue_in_i;
    side_in.space         = (red_in_i == '0);
    side_in.marks.coast   = coast_bit_i;
    side_in.marks.coast_l = coast_left_bit_i;
    side_in.marks.grid    = grid_bit_i;
    side_in.marks.fire    = fire_bit_i;
    side_in.marks.mark    = mark_bit_i;
    for (int i = 0; i < 3; i++) begin
      dist_d[i] = (side_in.pix[i] > lmin_eff) ? side_in.pix[i] - lmin_eff : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_SUB]) begin
      side_q[ST_SUB] <= side_in;
      dist_q         <= dist_d;
    end
    for (int k = ST_MUL; k < ST_RED; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage MUL: full scale times distance
  // ---------------------------------------------------------------------
  logic [2:0][PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_MUL]) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= PROD_W'(dcfg_q.full) * PROD_W'(dist_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stages DIV: product / window width, saturated to 16 bits
  // ---------------------------------------------------------------------
  logic [2:0][QUO_W-1:0] quo;

  for (genvar g = 0; g < 3; g++) begin : g_div
    psio_div u_div (
      .clk_i (clk_i),
      .en_i  (rdy[ST_DIV0 +: DIV_STAGES]),
      .num_i (prod_q[g]),
      .den_i (dcfg_q.den),
      .quo_o (quo[g])
    );
  end

  // ---------------------------------------------------------------------
  // Stage RED: invert, then depth reduction per mode
  // ---------------------------------------------------------------------
  side_t                    last_side;
  logic [2:0][FULL_W-1:0]   val;
  logic [2:0][BYTE_W-1:0]   col_d, col_q;
  logic [BYTE_W-1:0]        byte_d, byte_q;
  logic [FULL_W-1:0]        word_q;
  marks_t                   marks_q;

  assign last_side = side_q[ST_RED-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      val[i] = dcfg_q.stretch ? quo[i] : FULL_W'(last_side.pix[i]);
      if (inv && !last_side.space) begin
        val[i] = (dcfg_q.full > val[i]) ? dcfg_q.full - val[i] : '0;
      end
      if (!deep) begin
        col_d[i] = sat8(val[i]);
      end else if (adapt) begin
        col_d[i] = sat8(val[i] >> ADAPT_SHIFT);
      end else begin
        col_d[i] = sat8(val[i] >> dcfg_q.sh);
      end
    end
    if (mode_q == MODE_BYTE) begin
      byte_d = sat8(val[0]);
    end else if (adapt) begin
      byte_d = sat8(val[0] >> ADAPT_SHIFT);
    end else begin
      byte_d = sat8(val[0] >> dcfg_q.sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_RED]) begin
      col_q   <= col_d;
      byte_q  <= byte_d;
      word_q  <= val[0];
      marks_q <= last_side.marks;
    end
  end

  // ---------------------------------------------------------------------
  // Stage OUT: saturating tints and mode select into the output register
  // ---------------------------------------------------------------------
  logic                   ovl, grid, fire, mark;
  logic [2:0]             n_tint;
  logic [2:0][9:0]        csum;
  logic [2:0][LEVEL_W-1:0] add_a, add_b;
  logic [2:0][BYTE_W-1:0] col_out;
  logic [11:0]            bsum;
  logic [16:0]            wsum;
  logic [FULL_W-1:0]      word_out;
  logic [2:0][BYTE_W-1:0] rgb_d, rgb_q;
  logic [FULL_W-1:0]      mono_d, mono_q;

  assign ovl  = marks_q.coast && flags_q[FLAG_OVL];
  assign grid = marks_q.grid  && flags_q[FLAG_GRID];
  assign fire = marks_q.fire  && flags_q[FLAG_FIRE];
  assign mark = marks_q.mark  && flags_q[FLAG_MARK];
  assign n_tint = 3'(ovl) + 3'(grid) + 3'(fire) + 3'(mark);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d3) begin
        // left eye tints red, right eye green and blue; enables ignored
        if (i == 0) begin
          add_a[i] = marks_q.coast_l ? level_q : '0;
        end else begin
          add_a[i] = marks_q.coast ? level_q : '0;
        end
        add_b[i] = '0;
      end else begin
        add_a[i] = ovl  ? dcfg_q.tint_ovl[i]  : '0;
        add_b[i] = grid ? dcfg_q.tint_grid[i] : '0;
      end
      csum[i]    = 10'(col_q[i]) + 10'(add_a[i]) + 10'(add_b[i]);
      col_out[i] = sat8(FULL_W'(csum[i]));
    end
    if (!d3 && (fire || mark)) begin
      col_out[0] = 8'hff;
      col_out[1] = '0;
      col_out[2] = '0;
    end

    bsum = 12'(byte_q) + mul_n(n_tint, 10'(level_q));

    wsum = 17'(word_q) + 17'(mul_n(n_tint, dcfg_q.word_add));
    if (n_tint == 3'd0) begin
      word_out = word_q;
    end else if (wsum > 17'(WORD_CLIP)) begin
      word_out = WORD_CLIP;
    end else begin
      word_out = wsum[FULL_W-1:0];
    end

    rgb_d  = '0;
    mono_d = '0;
    case (mode_q)
      MODE_COLOUR:    rgb_d  = col_out;
      MODE_BYTE:      mono_d = FULL_W'(sat8(FULL_W'(bsum)));
      MODE_BYTE_WORD: mono_d = FULL_W'(sat8(FULL_W'(bsum)));
      MODE_WORD:      mono_d = word_out;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      rgb_q  <= rgb_d;
      mono_q <= mono_d;
    end
  end

  assign red_out_o   = rgb_q[0];
  assign green_out_o = rgb_q[1];
  assign blue_out_o  = rgb_q[2];
  assign mono_out_o  = mono_q;

`ifndef ASSERT_OFF
  // Only the output side can stall the pipe.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // Colour bytes and grey word are never both in use.
  a_outputs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mono_out_o == '0) ||
                    (red_out_o == '0 && green_out_o == '0 && blue_out_o == '0))
    else $error("colour and grey outputs both nonzero");

  // An item in the reduce stage is held while the output stage is blocked.
  a_reduce_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_RED] && !rdy[ST_OUT]) |=> v_q[ST_RED])
    else $error("item lost from reduce stage during stall");
`endif

endmodule
